// ----- design/olt_pkg.sv -----
`default_nettype none

package olt_pkg;

   localparam int DEFAULT_CAPACITY = 64;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int POS_W    = 6;
   localparam int POS_SPAN = 2 ** POS_W;
   localparam int LEN_W    = 7;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic             load;
      logic             step;
      logic             commit;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [POS_W-1:0] pos;
   } olt_ctl_type;

   // prefix word handed along the chain
   typedef struct packed {
      logic             hit;
      logic [KEY_W-1:0] pick;
   } olt_carry_type;

endpackage

`default_nettype wire

// ----- design/ordered_list_table_engine.sv -----
// Ordered list table engine: a list of up to CAPACITY signed 32-bit values kept
// in append order, one value per cell of a chain.
// Request beat (req_valid/req_ready): req_opcode append, remove first match,
// find or read at req_position, with req_key_value for the value.
// Response beat (rsp_valid/rsp_ready): status, value, length and empty flag
// after the operation, one beat per request.
// An append, or any operation on an empty list, goes from the request beat
// straight to commit; any other operation first passes through load and scan.
// In load each cell compares once; in scan the match and read words travel
// log2(CAPACITY) doubling hops along the chain.
// One request is worked at a time; the next is taken once the previous one
// has committed. A held response does not stop the next request beat.
// If the receiver stalls, a finished request waits in commit until the
// response register frees.
// Reset empties the list and drops any pending response; no clearing pass.
`default_nettype none

module ordered_list_table_engine #(
   parameter int CAPACITY = olt_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [olt_pkg::OP_W-1:0]            req_opcode,
   input  wire logic signed [olt_pkg::KEY_W-1:0]    req_key_value,
   input  wire logic [olt_pkg::POS_W-1:0]           req_position,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [olt_pkg::STATUS_W-1:0]             rsp_status,
   output logic signed [olt_pkg::KEY_W-1:0]         rsp_data_out,
   output logic [olt_pkg::LEN_W-1:0]                rsp_length,
   output logic                                     rsp_is_empty
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int LOG   = $clog2(CAPACITY);
   localparam int LVL_W = (LOG > 1) ? $clog2(LOG) : 1;

   olt_pkg::olt_ctl_type      ctl;
   logic [CNT_W-1:0]          count;
   logic [LVL_W-1:0]          level;
   logic [olt_pkg::KEY_W-1:0] rsp_data;
   logic [olt_pkg::KEY_W-1:0] entry [CAPACITY];
   olt_pkg::olt_carry_type    carry [CAPACITY];

   olt_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_key      ($unsigned(req_key_value)),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data),
      .rsp_length   (rsp_length),
      .rsp_is_empty (rsp_is_empty),
      .tail_carry   (carry[CAPACITY-1]),
      .ctl          (ctl),
      .count        (count),
      .level        (level)
   );

   assign rsp_data_out = $signed(rsp_data);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      olt_pkg::olt_carry_type    far [LOG];
      logic [olt_pkg::KEY_W-1:0] next;

      for (genvar k = 0; k < LOG; k++) begin : g_far
         if (i >= (1 << k)) begin : g_link
            assign far[k] = carry[i - (1 << k)];
         end else begin : g_head
            assign far[k] = '0;
         end
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next = entry[i];
      end else begin : g_mid
         assign next = entry[i + 1];
      end

      olt_cell #(
         .CAPACITY (CAPACITY),
         .IDX      (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count),
         .level      (level),
         .far_carry  (far),
         .next_entry (next),
         .entry      (entry[i]),
         .carry      (carry[i])
      );
   end

endmodule

`default_nettype wire

// ----- design/olt_cell.sv -----
`default_nettype none

module olt_cell #(
   parameter int CAPACITY = olt_pkg::DEFAULT_CAPACITY,
   parameter int IDX      = 0
) (
   input  wire logic                                   clock,
   input  wire olt_pkg::olt_ctl_type                   ctl,
   input  wire logic [$clog2(CAPACITY+1)-1:0]          count,
   input  wire logic [(($clog2(CAPACITY) > 1) ? $clog2($clog2(CAPACITY)) : 1)-1:0] level,
   input  wire olt_pkg::olt_carry_type                 far_carry [$clog2(CAPACITY)],
   input  wire logic [olt_pkg::KEY_W-1:0]              next_entry,
   output logic [olt_pkg::KEY_W-1:0]                   entry,
   output olt_pkg::olt_carry_type                      carry
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam bit POS_REACH = (IDX < olt_pkg::POS_SPAN);

   logic [olt_pkg::KEY_W-1:0] entry_ff, entry_in;
   olt_pkg::olt_carry_type    carry_ff, carry_in;
   logic                      in_range;
   logic                      at_tail;
   logic                      pos_hit;
   logic                      key_hit;

   assign in_range = (CNT_W'(IDX) < count);
   assign at_tail  = (CNT_W'(IDX) == count);
   assign pos_hit  = POS_REACH && (ctl.pos == olt_pkg::POS_W'(IDX));
   assign key_hit  = (entry_ff == ctl.key);

   always_comb begin
      entry_in = entry_ff;
      carry_in = carry_ff;
      if (ctl.load) begin
         if ((ctl.op == olt_pkg::OP_REMOVE) || (ctl.op == olt_pkg::OP_FIND)) begin
            carry_in.hit  = in_range && key_hit;
            carry_in.pick = '0;
         end else if (ctl.op == olt_pkg::OP_READ) begin
            carry_in.hit  = in_range && pos_hit;
            carry_in.pick = (in_range && pos_hit) ? entry_ff : '0;
         end else begin
            carry_in.hit  = 1'b0;
            carry_in.pick = '0;
         end
      end else if (ctl.step) begin
         // far_carry of a cell near the head is tied to zero
         carry_in.hit  = carry_ff.hit | far_carry[level].hit;
         carry_in.pick = carry_ff.pick | far_carry[level].pick;
      end
      if (ctl.commit) begin
         if ((ctl.op == olt_pkg::OP_APPEND) && at_tail) begin
            entry_in = ctl.key;
         end else if ((ctl.op == olt_pkg::OP_REMOVE) && carry_ff.hit) begin
            // at or past the first match: close up the gap
            entry_in = next_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      carry_ff <= carry_in;
   end

   assign entry = entry_ff;
   assign carry = carry_ff;

endmodule

`default_nettype wire

// ----- design/olt_seq.sv -----
`default_nettype none

module olt_seq #(
   parameter int CAPACITY = olt_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [olt_pkg::OP_W-1:0]               req_opcode,
   input  wire logic [olt_pkg::KEY_W-1:0]              req_key,
   input  wire logic [olt_pkg::POS_W-1:0]              req_position,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [olt_pkg::STATUS_W-1:0]                rsp_status,
   output logic [olt_pkg::KEY_W-1:0]                   rsp_data,
   output logic [olt_pkg::LEN_W-1:0]                   rsp_length,
   output logic                                        rsp_is_empty,
   input  wire olt_pkg::olt_carry_type                 tail_carry,
   output olt_pkg::olt_ctl_type                        ctl,
   output logic [$clog2(CAPACITY+1)-1:0]               count,
   output logic [(($clog2(CAPACITY) > 1) ? $clog2($clog2(CAPACITY)) : 1)-1:0] level
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int LOG   = $clog2(CAPACITY);
   localparam int LVL_W = (LOG > 1) ? $clog2(LOG) : 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOAD   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [LVL_W-1:0]              level_ff, level_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [olt_pkg::OP_W-1:0]      op_ff, op_in;
   logic [olt_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [olt_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [olt_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [olt_pkg::KEY_W-1:0]     data_ff, data_in;
   logic [olt_pkg::LEN_W-1:0]     length_ff, length_in;
   logic                          empty_ff, empty_in;

   logic             accept;
   logic             slot_free;
   logic             full;
   logic             empty;
   logic             change;
   logic [CNT_W-1:0] new_count;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      data_in      = data_ff;
      length_in    = length_ff;
      empty_in     = empty_ff;
      change       = 1'b0;
      new_count    = count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = req_opcode;
               key_in = req_key;
               pos_in = req_position;
               if ((req_opcode == olt_pkg::OP_APPEND) || empty) begin
                  state_in = S_COMMIT;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            level_in = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (level_ff == LVL_W'(LOG - 1)) begin
               state_in = S_COMMIT;
            end else begin
               level_in = level_ff + 1'b1;
            end
         end
         S_COMMIT: begin
            if (slot_free) begin
               status_in = olt_pkg::ST_OK;
               data_in   = key_ff;
               if (op_ff == olt_pkg::OP_APPEND) begin
                  if (full) begin
                     status_in = olt_pkg::ST_FULL;
                     data_in   = '0;
                  end else begin
                     change    = 1'b1;
                     new_count = count_ff + 1'b1;
                  end
               end else if (empty) begin
                  status_in = olt_pkg::ST_EMPTY;
                  data_in   = '0;
               end else if (!tail_carry.hit) begin
                  status_in = olt_pkg::ST_NOT_FOUND;
                  data_in   = '0;
               end else if (op_ff == olt_pkg::OP_REMOVE) begin
                  change    = 1'b1;
                  new_count = count_ff - 1'b1;
               end else if (op_ff == olt_pkg::OP_READ) begin
                  data_in = tail_carry.pick;
               end
               count_in     = new_count;
               length_in    = olt_pkg::LEN_W'(new_count);
               empty_in     = (new_count == '0);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      level_ff  <= level_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      length_ff <= length_in;
      empty_ff  <= empty_in;
   end

   always_comb begin
      ctl.load   = (state_ff == S_LOAD);
      ctl.step   = (state_ff == S_SCAN);
      ctl.commit = change;
      ctl.op     = op_ff;
      ctl.key    = key_ff;
      ctl.pos    = pos_ff;
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_data     = data_ff;
   assign rsp_length   = length_ff;
   assign rsp_is_empty = empty_ff;
   assign count        = count_ff;
   assign level        = level_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_COMMIT))
      else $error("response raised outside commit");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (change && (op_ff == olt_pkg::OP_APPEND)) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("append did not grow the list");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == olt_pkg::ST_EMPTY)) |-> (empty_ff && (length_ff == '0)))
      else $error("empty status with non-zero length");

   a_scan_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (level_ff <= LVL_W'(LOG - 1)))
      else $error("scan level out of range");

endmodule

`default_nettype wire
